// ----- hdl/zipfian_sample_mapper_defines.svh -----
// Assertion macros shared by the zipfian sample mapper RTL.
`ifndef ZIPFIAN_SAMPLE_MAPPER_DEFINES_SVH
`define ZIPFIAN_SAMPLE_MAPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ZSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ZSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/zsm_pkg.sv -----
// Types and constants for the zipfian sample mapper.
package zsm_pkg;

  localparam int unsigned CFG_IDX_W       = 4;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned U_W             = 32;
  localparam int unsigned ZETA_W          = 64;
  localparam int unsigned ETA_W           = 32;
  localparam int unsigned THR_W           = 32;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned ALPHA_W         = 32;
  localparam int unsigned ALPHA_FRAC_BITS = 24;
  localparam int unsigned ALPHA_INT_BITS  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALUE   = 4'd0,
    REG_RANGE_COUNT = 4'd1,
    REG_ZETA_N      = 4'd2,
    REG_ETA         = 4'd3,
    REG_ALPHA       = 4'd4,
    REG_SECOND_THR  = 4'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PATH_FIRST  = 2'd0,
    PATH_SECOND = 2'd1,
    PATH_POWER  = 2'd2
  } path_e;

  typedef struct packed {
    path_e                path;
    logic [VALUE_W-1:0]   sample;
  } result_t;

endpackage

// ----- hdl/zsm_mul.sv -----
// Two-stage unsigned multiplier built from four registered partial products.
module zsm_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] ll_d, ll_q;
  logic [AL+BH-1:0] lh_d, lh_q;
  logic [AH+BL-1:0] hl_d, hl_q;
  logic [AH+BH-1:0] hh_d, hh_q;
  logic [PW-1:0]    p_d, p_q;

  assign ll_d = a_i[AL-1:0] * b_i[BL-1:0];
  assign lh_d = a_i[AL-1:0] * b_i[BW-1:BL];
  assign hl_d = a_i[AW-1:AL] * b_i[BL-1:0];
  assign hh_d = a_i[AW-1:AL] * b_i[BW-1:BL];

  assign p_d = PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- hdl/zsm_pow.sv -----
// Pipelined fixed-point power: square-root ladder for fractional exponent bits, then squaring.
module zsm_pow
  import zsm_pkg::*;
#(
  parameter int unsigned F     = 32,
  parameter int unsigned TAG_W = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  input  logic               valid_i,
  input  logic [F:0]         v_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic [F:0]         acc_o,
  output logic [TAG_W-1:0]   tag_o
);

  localparam int unsigned W    = F + 1;
  localparam int unsigned RW   = F + 4;
  localparam int unsigned XW   = 2 * F + 2;
  localparam int unsigned LVLS = ALPHA_FRAC_BITS;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

  logic             lv_valid [LVLS+1];
  logic [W-1:0]     lv_acc   [LVLS+1];
  logic [W-1:0]     lv_s     [LVLS];
  logic [W-1:0]     lv_v     [LVLS+1];
  logic [TAG_W-1:0] lv_tag   [LVLS+1];

  assign lv_valid[0] = valid_i;
  assign lv_acc[0]   = ONE;
  assign lv_s[0]     = v_i;
  assign lv_v[0]     = v_i;
  assign lv_tag[0]   = tag_i;

  for (genvar L = 0; L < LVLS; L++) begin : g_lvl
    logic             dval  [W+1];
    logic [W-1:0]     dacc  [W+1];
    logic [W-1:0]     ds    [W];
    logic [W-1:0]     dorig [W+1];
    logic [W-1:0]     dr    [W+1];
    logic [RW-1:0]    drem  [W+1];
    logic [TAG_W-1:0] dtag  [W+1];
    logic [2*W-1:0]   prod;
    logic             m1_valid_q, m2_valid_q;
    logic [W-1:0]     m1_acc_q, m2_acc_q, m1_orig_q, m2_orig_q;
    logic [TAG_W-1:0] m1_tag_q, m2_tag_q;

    assign dval[0]  = lv_valid[L];
    assign dacc[0]  = lv_acc[L];
    assign ds[0]    = lv_s[L];
    assign dorig[0] = lv_v[L];
    assign dr[0]    = '0;
    assign drem[0]  = '0;
    assign dtag[0]  = lv_tag[L];

    // one root digit per stage
    for (genvar j = 0; j < W; j++) begin : g_dig
      localparam int unsigned I = F - j;
      logic [XW-1:0]    xw;
      logic [RW-1:0]    remsh, trial, rem_d, rem_q;
      logic             take;
      logic [W-1:0]     root_d, root_q, acc_q, orig_q;
      logic             valid_q;
      logic [TAG_W-1:0] tag_q;

      assign xw     = {1'b0, ds[j], {F{1'b0}}};
      assign remsh  = {drem[j][RW-3:0], xw[2*I+1 -: 2]};
      assign trial  = RW'({dr[j], 2'b01});
      assign take   = (remsh >= trial);
      assign rem_d  = take ? (remsh - trial) : remsh;
      assign root_d = {dr[j][W-2:0], take};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q <= 1'b0;
        end else if (en_i) begin
          valid_q <= dval[j];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q  <= rem_d;
          root_q <= root_d;
          acc_q  <= dacc[j];
          orig_q <= dorig[j];
          tag_q  <= dtag[j];
        end
      end

      if (j < W - 1) begin : g_src
        logic [W-1:0] s_q;
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            s_q <= ds[j];
          end
        end
        assign ds[j+1] = s_q;
      end

      assign dval[j+1]  = valid_q;
      assign drem[j+1]  = rem_q;
      assign dr[j+1]    = root_q;
      assign dacc[j+1]  = acc_q;
      assign dorig[j+1] = orig_q;
      assign dtag[j+1]  = tag_q;
    end

    zsm_mul #(.AW(W), .BW(W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (dacc[W]),
      .b_i   (dr[W]),
      .p_o   (prod)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m1_valid_q <= 1'b0;
        m2_valid_q <= 1'b0;
      end else if (en_i) begin
        m1_valid_q <= dval[W];
        m2_valid_q <= m1_valid_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m1_acc_q  <= dacc[W];
        m2_acc_q  <= m1_acc_q;
        m1_orig_q <= dorig[W];
        m2_orig_q <= m1_orig_q;
        m1_tag_q  <= dtag[W];
        m2_tag_q  <= m1_tag_q;
      end
    end

    if (L < LVLS - 1) begin : g_snext
      logic [W-1:0] m1_s_q, m2_s_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m1_s_q <= dr[W];
          m2_s_q <= m1_s_q;
        end
      end
      assign lv_s[L+1] = m2_s_q;
    end

    assign lv_valid[L+1] = m2_valid_q;
    assign lv_acc[L+1]   = alpha_i[ALPHA_FRAC_BITS-1-L] ? prod[2*F:F] : m2_acc_q;
    assign lv_v[L+1]     = m2_orig_q;
    assign lv_tag[L+1]   = m2_tag_q;
  end

  logic             iv_valid [ALPHA_INT_BITS+1];
  logic [W-1:0]     iv_acc   [ALPHA_INT_BITS+1];
  logic [W-1:0]     iv_p     [ALPHA_INT_BITS];
  logic [TAG_W-1:0] iv_tag   [ALPHA_INT_BITS+1];

  assign iv_valid[0] = lv_valid[LVLS];
  assign iv_acc[0]   = lv_acc[LVLS];
  assign iv_p[0]     = lv_v[LVLS];
  assign iv_tag[0]   = lv_tag[LVLS];

  // integer exponent bits, LSB first
  for (genvar k = 0; k < ALPHA_INT_BITS; k++) begin : g_int
    logic [2*W-1:0]   pa;
    logic             m1_valid_q, m2_valid_q;
    logic [W-1:0]     m1_acc_q, m2_acc_q;
    logic [TAG_W-1:0] m1_tag_q, m2_tag_q;

    zsm_mul #(.AW(W), .BW(W)) u_mul_acc (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (iv_acc[k]),
      .b_i   (iv_p[k]),
      .p_o   (pa)
    );

    if (k < ALPHA_INT_BITS - 1) begin : g_sq
      logic [2*W-1:0] pp;
      zsm_mul #(.AW(W), .BW(W)) u_mul_sq (
        .clk_i (clk_i),
        .en_i  (en_i),
        .a_i   (iv_p[k]),
        .b_i   (iv_p[k]),
        .p_o   (pp)
      );
      assign iv_p[k+1] = pp[2*F:F];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m1_valid_q <= 1'b0;
        m2_valid_q <= 1'b0;
      end else if (en_i) begin
        m1_valid_q <= iv_valid[k];
        m2_valid_q <= m1_valid_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m1_acc_q <= iv_acc[k];
        m2_acc_q <= m1_acc_q;
        m1_tag_q <= iv_tag[k];
        m2_tag_q <= m1_tag_q;
      end
    end

    assign iv_valid[k+1] = m2_valid_q;
    assign iv_acc[k+1]   = alpha_i[ALPHA_FRAC_BITS+k] ? pa[2*F:F] : m2_acc_q;
    assign iv_tag[k+1]   = m2_tag_q;
  end

  assign valid_o = iv_valid[ALPHA_INT_BITS];
  assign acc_o   = iv_acc[ALPHA_INT_BITS];
  assign tag_o   = iv_tag[ALPHA_INT_BITS];

endmodule

// ----- hdl/zipfian_sample_mapper.sv -----
// Top level of the zipfian sample mapper: config registers, front end, power core, scaling.
//
//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: uniform_sample
//  m_axis   | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: sample_value, tuser: path
//  cfg      | in        | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// One sample per cycle while the output skid is empty. Most of the pipeline is the
// 24 square-root ladders (one root digit per stage plus a 2-stage multiply each).
// Reset loads the register defaults; no clearing pass, input is ready right away.
// A skid register on the output; while it is full the whole pipe holds.
`include "zipfian_sample_mapper_defines.svh"

module zipfian_sample_mapper
  import zsm_pkg::*;
#(
  parameter int unsigned RANGE_BITS       = 48,
  parameter int unsigned SAMPLE_FRAC_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [U_W-1:0]        s_axis_tdata_i,   // [31:0] uniform_sample
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [VALUE_W-1:0]    m_axis_tdata_o,   // [63:0] sample_value
  output logic [1:0]            m_axis_tuser_o,   // [1:0] path_taken
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned F  = SAMPLE_FRAC_BITS;
  localparam int unsigned W  = F + 1;
  localparam int unsigned RB = RANGE_BITS;

  // config registers
  logic [VALUE_W-1:0] min_value_q;
  logic [RB-1:0]      range_count_q;
  logic [ZETA_W-1:0]  zeta_n_q;
  logic [ETA_W-1:0]   eta_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [THR_W-1:0]   second_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q   <= '0;
      range_count_q <= RB'(1);
      zeta_n_q      <= ZETA_W'(65536);
      eta_q         <= ETA_W'(32'h4000_0000);
      alpha_q       <= ALPHA_W'(32'h0100_0000);
      second_thr_q  <= THR_W'(32'h8000_0000);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MIN_VALUE:   min_value_q   <= cfg_data_i;
        REG_RANGE_COUNT: range_count_q <= cfg_data_i[RB-1:0];
        REG_ZETA_N:      zeta_n_q      <= cfg_data_i;
        REG_ETA:         eta_q         <= cfg_data_i[ETA_W-1:0];
        REG_ALPHA:       alpha_q       <= cfg_data_i[ALPHA_W-1:0];
        REG_SECOND_THR:  second_thr_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe advance and output skid
  logic    en;
  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  logic    f_valid;
  result_t f_data;

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;

  // front end: u*zeta and eta*(1-u)
  logic [U_W:0]              one_minus_u;
  logic [U_W+ZETA_W-1:0]     uz;
  logic [ETA_W+U_W:0]        ev;
  logic                      a1_valid_q, a2_valid_q, c_valid_q;
  path_e                     c_path_q, c_path_d;
  logic [W-1:0]              c_vf_q, c_vf_d;
  logic [62:0]               v62;

  assign one_minus_u = {1'b1, {U_W{1'b0}}} - {1'b0, s_axis_tdata_i};

  zsm_mul #(.AW(U_W), .BW(ZETA_W)) u_mul_uz (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (s_axis_tdata_i),
    .b_i   (zeta_n_q),
    .p_o   (uz)
  );

  zsm_mul #(.AW(ETA_W), .BW(U_W+1)) u_mul_eta (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (eta_q),
    .b_i   (one_minus_u),
    .p_o   (ev)
  );

  always_comb begin
    if (uz[U_W+ZETA_W-1:48] == '0) begin
      c_path_d = PATH_FIRST;
    end else if ((uz[U_W+ZETA_W-1:50] == '0) && (uz[49:0] < {second_thr_q, 18'b0})) begin
      c_path_d = PATH_SECOND;
    end else begin
      c_path_d = PATH_POWER;
    end
    v62 = (ev[ETA_W+U_W:62] != '0) ? 63'd0 : ({1'b1, 62'b0} - {1'b0, ev[61:0]});
    c_vf_d = v62[62 -: W];
    if (c_vf_d == '0) begin
      c_vf_d = W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      c_valid_q  <= 1'b0;
    end else if (en) begin
      a1_valid_q <= s_axis_tvalid_i;
      a2_valid_q <= a1_valid_q;
      c_valid_q  <= a2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_path_q <= c_path_d;
      c_vf_q   <= c_vf_d;
    end
  end

  // power core
  logic         p_valid;
  logic [W-1:0] p_acc;
  logic [1:0]   p_tag;

  zsm_pow #(.F(F), .TAG_W(2)) u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .alpha_i (alpha_q),
    .valid_i (c_valid_q),
    .v_i     (c_vf_q),
    .tag_i   (c_path_q),
    .valid_o (p_valid),
    .acc_o   (p_acc),
    .tag_o   (p_tag)
  );

  // scale by range count
  logic [RB+W-1:0] rp;
  logic            r1_valid_q, r2_valid_q;
  logic [1:0]      r1_path_q, r2_path_q;
  logic [RB:0]     off_full;
  logic [RB-1:0]   off;

  zsm_mul #(.AW(RB), .BW(W)) u_mul_rng (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (range_count_q),
    .b_i   (p_acc),
    .p_o   (rp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
    end else if (en) begin
      r1_valid_q <= p_valid;
      r2_valid_q <= r1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_path_q <= p_tag;
      r2_path_q <= r1_path_q;
    end
  end

  assign off_full = rp[RB+F:F];

  always_comb begin
    if (range_count_q == '0) begin
      off = '0;
    end else if (off_full >= {1'b0, range_count_q}) begin
      off = range_count_q - RB'(1);
    end else begin
      off = off_full[RB-1:0];
    end
    f_data.path = path_e'(r2_path_q);
    case (path_e'(r2_path_q))
      PATH_FIRST:  f_data.sample = min_value_q;
      PATH_SECOND: f_data.sample = min_value_q + VALUE_W'(1);
      default:     f_data.sample = min_value_q + VALUE_W'(off);
    endcase
  end

  assign f_valid = r2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready_i) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= f_valid;
    end else if (f_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready_i) begin
        out_data_q <= skid_data_q;
      end
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_data_q <= f_data;
    end else begin
      skid_data_q <= f_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q.sample;
  assign m_axis_tuser_o  = out_data_q.path;

  `ZSM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
  `ZSM_ASSERT_NEXT(a_skid_drain, skid_valid_q && m_axis_tready_i, out_valid_q && !skid_valid_q, "skid did not drain")
  `ZSM_ASSERT_NOW(a_first_is_min, m_axis_tvalid_o && (m_axis_tuser_o == PATH_FIRST), m_axis_tdata_o == min_value_q, "first path result is not the minimum")

endmodule

// ----- bench/testbench.sv -----
// Testbench for zipfian_sample_mapper: random and directed samples checked against a predictor.
module testbench;
  import zsm_pkg::*;

  localparam int unsigned FRAC      = 32;
  localparam int unsigned RBITS     = 48;
  localparam int unsigned LATENCY   = 24 * FRAC + 94;
  localparam int unsigned STALL_MAX = 20000;
  localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = CFG_IDX_W'(REG_SECOND_THR + 1);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [U_W-1:0]        s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [VALUE_W-1:0]    m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  zipfian_sample_mapper u_top (.*);

  // shadow copy of the register file
  logic [63:0] min_q;
  logic [63:0] range_q;
  logic [63:0] zeta_q;
  logic [31:0] eta_q;
  logic [31:0] alpha_q;
  logic [31:0] thr_q;

  logic [U_W-1:0] pending_samples[$];
  result_t        expected_values[$];
  int             errors;
  int             stall_cycles;
  bit             s_took, m_took, s_burst, m_burst;
  int             s_gap, m_gap;

  function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC+63:FRAC];
  endfunction

  function automatic logic [63:0] sqrt_frac(logic [63:0] x);
    logic [127:0] target;
    logic [63:0]  r;
    logic [63:0]  c;
    target = {64'd0, x} << FRAC;
    r = '0;
    for (int k = FRAC; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (({64'd0, c} * {64'd0, c}) <= target) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] power_frac(logic [63:0] v, logic [31:0] a);
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] p;
    acc = 64'd1 << FRAC;
    s = v;
    p = v;
    for (int k = ALPHA_FRAC_BITS - 1; k >= 0; k--) begin
      s = sqrt_frac(s);
      if (a[k]) acc = mul_frac(acc, s);
    end
    for (int k = 0; k < ALPHA_INT_BITS; k++) begin
      if (a[ALPHA_FRAC_BITS + k]) acc = mul_frac(acc, p);
      p = mul_frac(p, p);
    end
    return acc;
  endfunction

  function automatic result_t map_sample(logic [31:0] u);
    result_t      r;
    logic [127:0] uz;
    logic [127:0] scaled;
    logic [64:0]  prod;
    logic [63:0]  v62;
    logic [63:0]  vf;
    logic [63:0]  offset;
    uz = {96'd0, u} * {64'd0, zeta_q};
    if (uz < (128'd1 << 48)) begin
      r.path = PATH_FIRST;
      r.sample = min_q;
    end else if (uz < ({96'd0, thr_q} << 18)) begin
      r.path = PATH_SECOND;
      r.sample = min_q + 64'd1;
    end else begin
      prod = {33'd0, eta_q} * ((65'd1 << 32) - {33'd0, u});
      v62 = (prod >= (65'd1 << 62)) ? 64'd0 : 64'((65'd1 << 62) - prod);
      vf = v62 >> (62 - FRAC);
      if (vf == 0) vf = 64'd1;
      scaled = {64'd0, range_q} * {64'd0, power_frac(vf, alpha_q)};
      offset = scaled[FRAC+63:FRAC];
      if (range_q == 0) offset = '0;
      else if (offset >= range_q) offset = range_q - 64'd1;
      r.path = PATH_POWER;
      r.sample = min_q + offset;
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // sample driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_took)) begin
      if (s_gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        s_gap--;
      end else if (pending_samples.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_samples.pop_front();
        if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
        s_gap = s_burst ? 0 : $urandom_range(0, 14);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result ready driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_took) begin
        if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
        m_gap = m_burst ? 0 : $urandom_range(0, 14);
      end
      if (m_gap > 0) begin
        m_axis_tready_i <= 1'b0;
        m_gap--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    result_t e;
    s_took <= s_axis_tvalid_i && s_axis_tready_o;
    m_took <= m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_values.push_back(map_sample(s_axis_tdata_i));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result value=%h path=%0d", $time,
                   m_axis_tdata_o, m_axis_tuser_o);
          errors++;
        end else begin
          e = expected_values.pop_front();
          if (m_axis_tdata_o !== e.sample) begin
            $display("%0t: sample_value expected %h actual %h", $time, e.sample,
                     m_axis_tdata_o);
            errors++;
          end
          if (m_axis_tuser_o !== e.path) begin
            $display("%0t: path_taken expected %0d actual %0d", $time, e.path,
                     m_axis_tuser_o);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_MIN_VALUE:   min_q = data;
      REG_RANGE_COUNT: range_q = data & ((64'd1 << RBITS) - 1);
      REG_ZETA_N:      zeta_q = data;
      REG_ETA:         eta_q = data[31:0];
      REG_ALPHA:       alpha_q = data[31:0];
      REG_SECOND_THR:  thr_q = data[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] mn, logic [63:0] rc, logic [63:0] z,
                           logic [31:0] et, logic [31:0] al, logic [31:0] th);
    write_reg(REG_MIN_VALUE, mn);
    write_reg(REG_RANGE_COUNT, rc);
    write_reg(REG_ZETA_N, z);
    write_reg(REG_ETA, {$urandom, et});
    write_reg(REG_ALPHA, {$urandom, al});
    write_reg(REG_SECOND_THR, {$urandom, th});
    write_reg(CFG_IDX_W'($urandom_range(IDX_FIRST_UNUSED, 15)), {$urandom, $urandom});
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || expected_values.size() > 0 || s_axis_tvalid_i)
      @(posedge clk_i);
  endtask

  task automatic push_random(int n);
    logic [31:0] u;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       u = $urandom_range(0, 15);
        1:       u = 32'hFFFF_FFFF - $urandom_range(0, 15);
        default: u = $urandom;
      endcase
      pending_samples.push_back(u);
    end
  endtask

  initial begin
    errors = 0;
    stall_cycles = 0;
    s_took = 0;
    m_took = 0;
    s_burst = 0;
    m_burst = 0;
    s_gap = 0;
    m_gap = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    min_q = '0;
    range_q = 64'd1;
    zeta_q = 64'd65536;
    eta_q = 32'h4000_0000;
    alpha_q = 32'h0100_0000;
    thr_q = 32'h8000_0000;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults: everything maps to the first value
    pending_samples.push_back(32'h0);
    pending_samples.push_back(32'hFFFF_FFFF);
    push_random(40);
    drain;

    // directed: path boundaries at zeta 4.0, threshold 1.5
    write_all(64'd1000, 64'd100000, 64'd4 << 16, 32'h3999_999A, 32'h0200_0000, 32'h6000_0000);
    pending_samples.push_back(32'h0);
    pending_samples.push_back(32'h1);
    pending_samples.push_back(32'h3FFF_FFFF);
    pending_samples.push_back(32'h4000_0000);
    pending_samples.push_back(32'h5FFF_FFFF);
    pending_samples.push_back(32'h6000_0000);
    pending_samples.push_back(32'h6000_0001);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'hFFFF_FFFE);
    pending_samples.push_back(32'hFFFF_FFFF);
    push_random(150);
    drain;

    // eta too large: v clamps to one step; wrap of min_value
    write_all(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd20 << 16, 32'hFFFF_FFFF,
              32'h0100_0000, 32'h4000_0000);
    push_random(150);
    drain;

    // eta zero: v is one; range_count 1<<RBITS truncates to zero, so the offset is zero
    write_all(64'hFFFF_FFFF_FFFF_FFF0, 64'd1 << RBITS, 64'd50 << 16, 32'h0, 32'hFFFF_FFFF,
              32'h8000_0000);
    push_random(150);
    drain;

    // empty range, huge zeta
    write_all({$urandom, $urandom}, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 32'h0180_0000,
              $urandom_range(32'h4000_0000, 32'h8000_0000));
    push_random(150);
    drain;

    // zeta zero: always first value
    write_all({$urandom, $urandom}, 64'd12345, 64'd0, $urandom, $urandom, 32'h4000_0000);
    push_random(60);
    drain;

    // random realistic settings
    for (int ph = 0; ph < 8; ph++) begin
      write_all({$urandom, $urandom},
                ph[0] ? {$urandom, $urandom} : {32'd0, $urandom_range(1, 5000)},
                {32'd0, $urandom_range(32'h0001_8000, 32'h0030_0000)},
                $urandom_range(32'h3000_0000, 32'h4000_0000),
                ph[1] ? $urandom : $urandom_range(32'h0100_0000, 32'h0800_0000),
                $urandom_range(32'h4000_0000, 32'h8000_0000));
      push_random(125);
      drain;
    end

    repeat (LATENCY + 100) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
